// File: design/frx_pkg.sv
package frx_pkg;

  // input item kinds
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // result events
  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_POLL    = 4'd1;
  localparam logic [3:0] EV_ACCEPT  = 4'd2;
  localparam logic [3:0] EV_BAD_ETX = 4'd3;
  localparam logic [3:0] EV_BAD_SUM = 4'd4;
  localparam logic [3:0] EV_TOO_LONG = 4'd5;
  localparam logic [3:0] EV_SHORT   = 4'd6;
  localparam logic [3:0] EV_TIMEOUT = 4'd7;
  localparam logic [3:0] EV_READ    = 4'd8;

  // configuration register indexes
  localparam logic REG_IDLE_LIMIT  = 1'b0;
  localparam logic REG_PARAM_LIMIT = 1'b1;

  // control characters
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CMD_DOUBLE_ACK = 8'h53;

  localparam logic [15:0] IDLE_LIMIT_RST  = 16'd5000;
  localparam logic [7:0]  PARAM_LIMIT_RST = 8'd220;
  localparam logic [8:0]  MIN_FRAME = 9'd8;
  localparam logic [8:0]  PARAM_START = 9'd6;

  typedef struct packed {
    logic [3:0] event_res;
    logic [1:0] reply_count;
    logic [7:0] reply_byte;
    logic [7:0] frame_command;
    logic [7:0] param_count;
  } res_t;

  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
    logic       re;
  } mem_ctrl_t;

endpackage

// File: design/stx_etx_xor_frame_receiver.sv
// Receiver for STX/ETX framed serial packets with an XOR checksum. Each input transfer is a
// received byte, an idle tick or a read of an accepted parameter, and gives exactly one result
// transfer: an event code with the ACK/NACK reply to send, the latched command and parameter
// count of the last good frame, and the parameter byte on a read. One item is taken every clock
// while the output is not stalled. The frame update and the registered read of the two-bank
// parameter memory feed a result stage and then an output register, which let the block take
// one more item while a result waits. The parameter memory holds two banks of BANK_DEPTH bytes,
// needs no clearing after reset, and returns zero for reads beyond the count or the bank.
module stx_etx_xor_frame_receiver #(
  parameter int BANK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], param_index[15:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // reply_count[1:0], reply_byte[9:2], frame_command[17:10], param_count[25:18],
  // read_data[33:26], zero[39:34]
  output logic [39:0] out_tdata,
  output logic [3:0]  out_tuser   // event_res[3:0]
);
  import frx_pkg::*;

  localparam int AW = $clog2(2 * BANK_DEPTH);

  logic      in_acc;
  logic      s1_v_r;
  res_t      s1_res_r;
  logic      s1_rd_ok_r;
  logic      s1_adv;
  res_t      res;
  logic      rd_ok;
  mem_ctrl_t mem_ctrl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic      out_v_r;
  res_t      out_res_r;
  logic [7:0] out_rd_r;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  frx_parser #(.BANK_DEPTH(BANK_DEPTH), .AW(AW)) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_acc     (in_acc),
    .command    (in_tuser),
    .rx_byte    (in_tdata[7:0]),
    .param_index(in_tdata[15:8]),
    .res        (res),
    .rd_ok      (rd_ok),
    .mem_ctrl   (mem_ctrl),
    .waddr      (waddr),
    .raddr      (raddr)
  );

  frx_param_mem #(.DEPTH(2 * BANK_DEPTH), .AW(AW)) u_mem (
    .clk  (clk),
    .ctrl (mem_ctrl),
    .waddr(waddr),
    .raddr(raddr),
    .rdata(rdata)
  );

  // result stage lines up with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r   <= res;
      s1_rd_ok_r <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= s1_res_r;
      out_rd_r  <= s1_rd_ok_r ? rdata : 8'h00;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.event_res;
  assign out_tdata  = {6'd0, out_rd_r, out_res_r.param_count, out_res_r.frame_command,
                       out_res_r.reply_byte, out_res_r.reply_count};

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r)
    else $error("result stage lost an item");

  a_read_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_res_r.event_res != EV_READ) |-> out_rd_r == 8'h00)
    else $error("read data leaked into a non-read result");

  a_ack_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_res_r.event_res == EV_ACCEPT) |->
      (out_res_r.reply_byte == CH_ACK) && (out_res_r.reply_count != 2'd0))
    else $error("accepted frame without acknowledge");

  a_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_res_r.reply_count == 2'd0) |-> out_res_r.reply_byte == 8'h00)
    else $error("reply byte without reply count");
`endif

endmodule

// File: design/frx_param_mem.sv
module frx_param_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic              clk,
  input  frx_pkg::mem_ctrl_t ctrl,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     raddr,
  output logic [7:0]        rdata
);
  import frx_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[waddr] <= ctrl.wdata;
    end
    if (ctrl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/frx_parser.sv
module frx_parser #(
  parameter int BANK_DEPTH = 256,
  parameter int AW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_acc,
  input  logic [1:0]         command,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         param_index,
  output frx_pkg::res_t      res,
  output logic               rd_ok,
  output frx_pkg::mem_ctrl_t mem_ctrl,
  output logic [AW-1:0]      waddr,
  output logic [AW-1:0]      raddr
);
  import frx_pkg::*;

  localparam int OW = $clog2(BANK_DEPTH);
  localparam logic [AW-1:0] BANK1_BASE = AW'(BANK_DEPTH);
  localparam logic [8:0] BANK_LIMIT = 9'(BANK_DEPTH);

  logic [15:0] idle_limit_r;
  logic [7:0]  param_limit_r;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  pcmd_r, pcmd_nxt;
  logic        etx_ok_r, etx_ok_nxt;
  logic        bank_r, bank_nxt;
  logic [7:0]  acc_cmd_r, acc_cmd_nxt;
  logic [7:0]  acc_cnt_r, acc_cnt_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic [7:0]  len_v;
  logic [8:0]  pos_inc;
  logic [8:0]  woff;
  logic [15:0] idle_inc;
  logic [3:0]  ev;
  logic [1:0]  nrep;
  logic [7:0]  reply;
  logic        wr_ok;

  assign woff = pos_r - PARAM_START;
  assign idle_inc = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;
  assign wr_ok = (pos_r >= PARAM_START) && (pos_r < {1'b0, len_r}) && (woff < BANK_LIMIT);

  // parameters go to the bank that is not being read
  assign waddr = bank_r ? AW'(woff[OW-1:0]) : BANK1_BASE + AW'(woff[OW-1:0]);
  assign raddr = bank_r ? BANK1_BASE + AW'(param_index[OW-1:0])
                        : AW'(param_index[OW-1:0]);

  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    xor_nxt     = xor_r;
    pcmd_nxt    = pcmd_r;
    etx_ok_nxt  = etx_ok_r;
    bank_nxt    = bank_r;
    acc_cmd_nxt = acc_cmd_r;
    acc_cnt_nxt = acc_cnt_r;
    idle_nxt    = idle_r;
    ev          = EV_NONE;
    nrep        = 2'd0;
    reply       = 8'h00;
    len_v       = len_r;
    pos_inc     = pos_r + 9'd1;
    mem_ctrl    = '{we: 1'b0, wdata: rx_byte, re: 1'b0};
    rd_ok       = 1'b0;
    if (in_acc) begin
      unique case (command)
        CMD_BYTE: begin
          idle_nxt = 16'd0;
          if (pos_r == 9'd0) begin
            if (rx_byte == CH_ENQ) begin
              ev = EV_POLL;
            end else if (rx_byte == CH_STX) begin
              pos_nxt    = 9'd1;
              etx_ok_nxt = 1'b0;
              xor_nxt    = 8'h00;
            end
          end else begin
            if (pos_r == 9'd1) begin
              len_nxt = rx_byte;
              xor_nxt = rx_byte;
              len_v   = rx_byte;
            end else begin
              if (pos_r == 9'd2) begin
                pcmd_nxt = rx_byte;
              end
              if (pos_r <= {1'b0, len_r}) begin
                xor_nxt = xor_r ^ rx_byte;
              end
              if (pos_r == {1'b0, len_r}) begin
                etx_ok_nxt = (rx_byte == CH_ETX);
              end
              mem_ctrl.we = wr_ok;
            end
            // the byte after the ETX position carries the checksum
            if (pos_inc == {1'b0, len_v} + 9'd2) begin
              pos_nxt = 9'd0;
              if (pos_inc < MIN_FRAME) begin
                ev = EV_SHORT;
              end else if (!etx_ok_nxt) begin
                ev = EV_BAD_ETX;
                nrep = 2'd1;
                reply = CH_NAK;
              end else if (xor_nxt != rx_byte) begin
                ev = EV_BAD_SUM;
                nrep = 2'd1;
                reply = CH_NAK;
              end else if (len_v - 8'd6 > param_limit_r) begin
                ev = EV_TOO_LONG;
                nrep = 2'd1;
                reply = CH_NAK;
              end else begin
                ev = EV_ACCEPT;
                acc_cmd_nxt = pcmd_nxt;
                acc_cnt_nxt = len_v - 8'd6;
                bank_nxt = ~bank_r;
                nrep = (pcmd_nxt == CMD_DOUBLE_ACK) ? 2'd2 : 2'd1;
                reply = CH_ACK;
              end
            end else begin
              pos_nxt = pos_inc;
            end
          end
        end
        CMD_TICK: begin
          if (pos_r != 9'd0) begin
            if (idle_inc >= idle_limit_r) begin
              pos_nxt  = 9'd0;
              idle_nxt = 16'd0;
              ev = EV_TIMEOUT;
            end else begin
              idle_nxt = idle_inc;
            end
          end
        end
        CMD_READ: begin
          ev = EV_READ;
          mem_ctrl.re = 1'b1;
          rd_ok = (param_index < acc_cnt_r) && ({1'b0, param_index} < BANK_LIMIT);
        end
        CMD_NOP: begin
          ev = EV_NONE;
        end
        default: begin
          ev = EV_NONE;
        end
      endcase
    end
    res = '{event_res: ev, reply_count: nrep, reply_byte: reply,
            frame_command: acc_cmd_nxt, param_count: acc_cnt_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r  <= IDLE_LIMIT_RST;
      param_limit_r <= PARAM_LIMIT_RST;
      pos_r     <= 9'd0;
      len_r     <= 8'd0;
      xor_r     <= 8'd0;
      pcmd_r    <= 8'd0;
      etx_ok_r  <= 1'b0;
      bank_r    <= 1'b0;
      acc_cmd_r <= 8'd0;
      acc_cnt_r <= 8'd0;
      idle_r    <= 16'd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_IDLE_LIMIT:  idle_limit_r  <= cfg_wdata;
          REG_PARAM_LIMIT: param_limit_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      xor_r     <= xor_nxt;
      pcmd_r    <= pcmd_nxt;
      etx_ok_r  <= etx_ok_nxt;
      bank_r    <= bank_nxt;
      acc_cmd_r <= acc_cmd_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      idle_r    <= idle_nxt;
    end
  end

endmodule

// File: tb/stx_etx_xor_frame_receiver_test.sv
`timescale 1ns / 1ps

module stx_etx_xor_frame_receiver_test;
  import frx_pkg::*;

  localparam int BANK_BYTES = 256;

  typedef struct packed {
    logic [3:0] ev;
    logic [1:0] nrep;
    logic [7:0] reply;
    logic [7:0] cmd;
    logic [7:0] cnt;
    logic [7:0] rd;
  } frame_result_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_ETX, FRAME_BAD_SUM} frame_fault_e;

  class frame_tracker;
    logic [15:0] idle_limit;
    logic [7:0]  param_limit;
    logic [8:0]  pos;
    logic [7:0]  len_byte;
    logic [7:0]  xor_acc;
    logic [7:0]  cmd_held;
    bit          etx_ok;
    logic [7:0]  store [0:2*BANK_BYTES-1];
    bit          bank_sel;
    logic [7:0]  last_cmd;
    logic [7:0]  last_count;
    logic [15:0] idle_ticks;
    frame_result_t awaited[$];
    int errors;

    function new();
      idle_limit = IDLE_LIMIT_RST;
      param_limit = PARAM_LIMIT_RST;
      pos = '0;
      len_byte = '0;
      xor_acc = '0;
      cmd_held = '0;
      etx_ok = 1'b0;
      bank_sel = 1'b0;
      last_cmd = '0;
      last_count = '0;
      idle_ticks = '0;
      errors = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_limits(logic [15:0] idle, logic [7:0] plimit);
      idle_limit = idle;
      param_limit = plimit;
    endfunction

    // works out the result of one accepted input transfer
    function void note_transfer(logic [1:0] kind, logic [7:0] b, logic [7:0] idx);
      frame_result_t r;
      int at;
      int plen;
      r = '0;
      at = pos;
      plen = len_byte;
      case (kind)
        CMD_BYTE: begin
          idle_ticks = '0;
          if (at == 0) begin
            if (b == CH_ENQ) begin
              r.ev = EV_POLL;
            end else if (b == CH_STX) begin
              pos = 9'd1;
              etx_ok = 1'b0;
              xor_acc = '0;
            end
          end else begin
            if (at == 1) begin
              len_byte = b;
              xor_acc = b;
              plen = b;
            end else begin
              if (at == 2) cmd_held = b;
              if (at <= plen) xor_acc ^= b;
              if (at == plen) etx_ok = (b == CH_ETX);
              if (at >= int'(PARAM_START) && at < plen && at - 6 < BANK_BYTES)
                store[(bank_sel ? 0 : BANK_BYTES) + at - 6] = b;
            end
            at++;
            pos = 9'(at);
            if (at == plen + 2) begin
              pos = '0;
              if (at < int'(MIN_FRAME)) begin
                r.ev = EV_SHORT;
              end else if (!etx_ok) begin
                r.ev = EV_BAD_ETX;
                r.nrep = 2'd1;
                r.reply = CH_NAK;
              end else if (xor_acc != b) begin
                r.ev = EV_BAD_SUM;
                r.nrep = 2'd1;
                r.reply = CH_NAK;
              end else if (plen - 6 > int'(param_limit)) begin
                r.ev = EV_TOO_LONG;
                r.nrep = 2'd1;
                r.reply = CH_NAK;
              end else begin
                last_cmd = cmd_held;
                last_count = 8'(plen - 6);
                bank_sel = ~bank_sel;
                r.ev = EV_ACCEPT;
                r.nrep = (cmd_held == CMD_DOUBLE_ACK) ? 2'd2 : 2'd1;
                r.reply = CH_ACK;
              end
            end
          end
        end
        CMD_TICK: begin
          if (pos != 0) begin
            if (idle_ticks != 16'hFFFF) idle_ticks++;
            if (idle_ticks >= idle_limit) begin
              pos = '0;
              idle_ticks = '0;
              r.ev = EV_TIMEOUT;
            end
          end
        end
        CMD_READ: begin
          r.ev = EV_READ;
          if (idx < last_count && idx < BANK_BYTES)
            r.rd = store[(bank_sel ? BANK_BYTES : 0) + idx];
        end
        default: ;
      endcase
      r.cmd = last_cmd;
      r.cnt = last_count;
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [3:0] ev, logic [39:0] d);
      frame_result_t e;
      if (awaited.size() == 0) begin
        $error("result with no pending item: event_res %0d", ev);
        errors++;
        return;
      end
      e = awaited.pop_front();
      compare_field("event_res", 8'(e.ev), 8'(ev));
      compare_field("reply_count", 8'(e.nrep), 8'(d[1:0]));
      compare_field("reply_byte", e.reply, d[9:2]);
      compare_field("frame_command", e.cmd, d[17:10]);
      compare_field("param_count", e.cnt, d[25:18]);
      compare_field("read_data", e.rd, d[33:26]);
    endfunction
  endclass

  localparam int QUIET_LIMIT = 1000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // rx_byte[7:0], param_index[15:8]
  logic [1:0]  in_tuser;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready;
  // reply_count[1:0], reply_byte[9:2], frame_command[17:10], param_count[25:18],
  // read_data[33:26], zero[39:34]
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;  // event_res[3:0]

  frame_tracker tracker;
  int burst_left;
  int items_done;
  int stall_mode;
  int stall_left;
  int cyc;

  stx_etx_xor_frame_receiver #(.BANK_DEPTH(BANK_BYTES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check every transfer, then pick next ready value
  always @(posedge clk) begin
    if (out_tvalid && out_tready) tracker.check_reply(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    cyc++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 2) != 0);
      2: out_tready <= (cyc % 7) < 4;
      default: out_tready <= (cyc % 16) >= 12;
    endcase
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send(input logic [1:0] kind, input logic [7:0] b, input logic [7:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {idx, b};
    do @(posedge clk); while (!in_tready);
    tracker.note_transfer(kind, b, idx);
    items_done++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(CMD_BYTE, b, 8'($urandom));
  endtask

  task automatic send_tick();
    send(CMD_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_read(input logic [7:0] idx);
    send(CMD_READ, 8'($urandom), idx);
  endtask

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, int'(tracker.last_count) + 1));
  endfunction

  // full frame: STX, length, command, three header bytes, parameters, ETX, checksum
  task automatic send_frame(input logic [7:0] cmd_byte, input int nparam,
                            input frame_fault_e fault, input bit mix);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] tail;
    int plen;
    plen = nparam + 6;
    fb.push_back(CH_STX);
    fb.push_back(8'(plen));
    fb.push_back(cmd_byte);
    for (int i = 3; i < plen; i++) fb.push_back(8'($urandom));
    tail = CH_ETX;
    if (fault == FRAME_BAD_ETX) begin
      tail = 8'($urandom);
      if (tail == CH_ETX) tail = 8'h04;
    end
    fb.push_back(tail);
    sum = '0;
    for (int i = 1; i < fb.size(); i++) sum ^= fb[i];
    if (fault == FRAME_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
    fb.push_back(sum);
    foreach (fb[i]) begin
      if (mix && $urandom_range(0, 19) == 0) send_read(pick_index());
      if (mix && $urandom_range(0, 39) == 0) send_tick();
      send_byte(fb[i]);
    end
  endtask

  task automatic send_short(input int plen);
    send_byte(CH_STX);
    send_byte(8'(plen));
    repeat (plen) send_byte(8'($urandom));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] idle, input logic [7:0] plimit);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_IDLE_LIMIT;
    cfg_wdata <= idle;
    @(posedge clk);
    cfg_addr <= REG_PARAM_LIMIT;
    cfg_wdata <= {8'h00, plimit};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_limits(idle, plimit);
  endtask

  task automatic run_mix(input int target);
    int pick;
    int lim;
    int nparam;
    frame_fault_e fault;
    logic [7:0] cmd_byte;
    while (items_done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        cmd_byte = ($urandom_range(0, 4) == 0) ? CMD_DOUBLE_ACK : 8'($urandom);
        nparam = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 249)
                                              : $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          0: fault = FRAME_BAD_ETX;
          1: fault = FRAME_BAD_SUM;
          default: fault = FRAME_GOOD;
        endcase
        send_frame(cmd_byte, nparam, fault, 1'b1);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 6)) send_read(pick_index());
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 5))
          send_byte(($urandom_range(0, 3) == 0) ? CH_ENQ : 8'($urandom));
      end else if (pick < 88) begin
        // frame cut off, then idle ticks to run out the timeout where it is short
        lim = $urandom_range(6, 30);
        send_byte(CH_STX);
        send_byte(8'(lim));
        repeat ($urandom_range(0, lim - 1)) send_byte(8'($urandom));
        repeat ((tracker.idle_limit <= 40) ? int'(tracker.idle_limit) : 3) send_tick();
      end else if (pick < 95) begin
        send_short($urandom_range(0, 5));
      end else begin
        send(CMD_NOP, 8'($urandom), 8'($urandom));
        send_tick();
      end
    end
  endtask

  initial begin
    tracker = new();
    burst_left = 0;
    items_done = 0;
    stall_mode = 0;
    stall_left = 0;
    cyc = 0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= REG_IDLE_LIMIT;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= CMD_NOP;
    out_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // hunting behavior, reads before any frame, double ack, short frame
    send_byte(CH_ENQ);
    send_byte(8'hFF);
    send_tick();
    send(CMD_NOP, 8'hFF, 8'hFF);
    send_read(8'd0);
    send_frame(CMD_DOUBLE_ACK, 1, FRAME_GOOD, 1'b0);
    send_read(8'd0);
    send_read(8'd1);
    send_short(0);

    // no parameters allowed, one-tick timeout
    set_limits(16'd1, 8'd0);
    send_frame(8'h41, 1, FRAME_GOOD, 1'b0);
    send_frame(8'h00, 0, FRAME_GOOD, 1'b0);
    send_byte(CH_STX);
    send_byte(8'd10);
    send_tick();
    run_mix(130);

    // largest frame and a long idle timeout
    set_limits(16'hFFFF, 8'd249);
    send_frame(8'hAC, 249, FRAME_GOOD, 1'b0);
    send_read(8'd0);
    send_read(8'd248);
    send_read(8'd249);
    send_read(8'd255);
    send_byte(CH_STX);
    send_byte(8'd20);
    repeat (3) send_tick();
    run_mix(300);

    set_limits(16'd3, 8'd20);
    run_mix(430);

    set_limits(16'd40, 8'd128);
    run_mix(550);

    settle();
    repeat (6) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
